@@ design/xysp_pkg.sv @@
// Shared types, constants and lookup tables of the two-axis sine color block.
`default_nettype none

package xysp_pkg;

    // Display geometry that sets the angle scale of each axis.
    localparam int unsigned LETTER_COUNT  = 8;
    localparam int unsigned LETTER_WIDTH  = 8;
    localparam int unsigned HEIGHT_PIXELS = 11;

    localparam int unsigned EXT_X = LETTER_COUNT * LETTER_WIDTH * 256;
    localparam int unsigned EXT_Y = HEIGHT_PIXELS * 256;

    // Full-scale angle per unit of coordinate before the extent divide.
    localparam logic [31:0] ANGLE_FULL = 32'd65535;

    // Unsigned divide by 255 as a multiply by a rounded-up reciprocal.
    localparam logic [31:0] RECIP_255   = 32'h8080_8081;
    localparam int unsigned RECIP_SHIFT = 39;

    // Offset that centers the wave sum for the value channel.
    localparam logic [15:0] VAL_OFFSET = 16'd32767;

    localparam int unsigned ANG_W = 24;
    localparam int unsigned MAG_W = 15;

    typedef logic [ANG_W-1:0] t_ang_tab [256];

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_FREQ_X    = 3'd0;
    localparam t_reg_idx REG_FREQ_Y    = 3'd1;
    localparam t_reg_idx REG_STEP_X    = 3'd2;
    localparam t_reg_idx REG_STEP_Y    = 3'd3;
    localparam t_reg_idx REG_BASE_HUE  = 3'd4;
    localparam t_reg_idx REG_BASE_SAT  = 3'd5;
    localparam t_reg_idx REG_BASE_VAL  = 3'd6;
    localparam t_reg_idx REG_WAVE_VAL  = 3'd7;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] hue16;
        logic [15:0] sat16;
        logic [15:0] val16;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] freq_x;
        logic [7:0] freq_y;
        logic [7:0] base_hue;
        logic [7:0] base_sat;
        logic [7:0] base_val;
        logic       wave_drives_value;
    } t_cfg;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] phase;
    } t_axis_ang;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_axis_sine;

    // Piecewise-linear quarter wave: eight segments, base and slope each.
    localparam logic [MAG_W-1:0] SINE_BASE [8] = '{
        15'd0, 15'd6393, 15'd12539, 15'd18204,
        15'd23170, 15'd27245, 15'd30273, 15'd32137
    };
    localparam logic [5:0] SINE_SLOPE [8] = '{
        6'd49, 6'd48, 6'd44, 6'd38, 6'd31, 6'd23, 6'd14, 6'd4
    };

    // Coordinate to unscaled angle, one entry per coordinate value.
    function automatic t_ang_tab build_ang_x();
        t_ang_tab    tab;
        logic [31:0] num;
        for (int c = 0; c < 256; c++) begin
            num    = (32'(c) << 8) * ANGLE_FULL;
            tab[c] = ANG_W'(num / EXT_X);
        end
        return tab;
    endfunction

    function automatic t_ang_tab build_ang_y();
        t_ang_tab    tab;
        logic [31:0] num;
        for (int c = 0; c < 256; c++) begin
            num    = (32'(c) << 8) * ANGLE_FULL;
            tab[c] = ANG_W'(num / EXT_Y);
        end
        return tab;
    endfunction

    localparam t_ang_tab ANG_TAB_X = build_ang_x();
    localparam t_ang_tab ANG_TAB_Y = build_ang_y();

endpackage

`default_nettype wire

@@ design/xysp_angle.sv @@
// Angle pipeline: coordinate lookup, frequency scale and divide by 255 for both axes.
`default_nettype none

module xysp_angle (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_pixel_x,
    input  wire logic [7:0]           i_pixel_y,
    input  wire logic [15:0]          i_phase_x,
    input  wire logic [15:0]          i_phase_y,
    input  wire xysp_pkg::t_cfg       i_cfg,
    output logic                      o_valid,
    output xysp_pkg::t_axis_ang       o_ang_x,
    output xysp_pkg::t_axis_ang       o_ang_y
);

    logic                         r_v1, r_v2, r_v3;
    logic [xysp_pkg::ANG_W-1:0]   r_a0_x, r_a0_y;
    logic [31:0]                  r_a2_x, r_a2_y;
    logic [15:0]                  r_ph1_x, r_ph1_y, r_ph2_x, r_ph2_y;
    logic [15:0]                  r_q_x, r_q_y, r_ph3_x, r_ph3_y;

    logic [31:0] n_prod_x, n_prod_y;
    logic [31:0] n_a2_x, n_a2_y;
    logic [63:0] n_rec_x, n_rec_y;

    always_comb begin
        // Scale by frequency; the X axis runs at twice the spatial rate.
        n_prod_x = 32'(r_a0_x) * 32'(i_cfg.freq_x);
        n_prod_y = 32'(r_a0_y) * 32'(i_cfg.freq_y);
        n_a2_x   = {n_prod_x[30:0], 1'b0};
        n_a2_y   = n_prod_y;
        n_rec_x  = 64'(r_a2_x) * 64'(xysp_pkg::RECIP_255);
        n_rec_y  = 64'(r_a2_y) * 64'(xysp_pkg::RECIP_255);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0_x  <= xysp_pkg::ANG_TAB_X[i_pixel_x];
            r_a0_y  <= xysp_pkg::ANG_TAB_Y[i_pixel_y];
            r_ph1_x <= i_phase_x;
            r_ph1_y <= i_phase_y;
            r_a2_x  <= n_a2_x;
            r_a2_y  <= n_a2_y;
            r_ph2_x <= r_ph1_x;
            r_ph2_y <= r_ph1_y;
            r_q_x   <= n_rec_x[xysp_pkg::RECIP_SHIFT +: 16];
            r_q_y   <= n_rec_y[xysp_pkg::RECIP_SHIFT +: 16];
            r_ph3_x <= r_ph2_x;
            r_ph3_y <= r_ph2_y;
        end
    end

    assign o_valid       = r_v3;
    assign o_ang_x.angle = r_q_x;
    assign o_ang_x.phase = r_ph3_x;
    assign o_ang_y.angle = r_q_y;
    assign o_ang_y.phase = r_ph3_y;

endmodule

`default_nettype wire

@@ design/xysp_sine.sv @@
// Phase add and piecewise-linear sine of one axis, one register stage.
`default_nettype none

module xysp_sine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire xysp_pkg::t_axis_ang  i_ang,
    output logic                      o_valid,
    output xysp_pkg::t_axis_sine      o_sine
);

    logic                         r_valid;
    xysp_pkg::t_axis_sine         r_sine;

    logic [15:0]                  n_theta;
    logic [10:0]                  n_pos;
    logic [2:0]                   n_seg;
    logic [6:0]                   n_frac;
    xysp_pkg::t_axis_sine         n_sine;

    always_comb begin
        n_theta = i_ang.angle + i_ang.phase;
        // The second quadrant of each half wave runs the table backward.
        n_pos   = n_theta[14] ? ~n_theta[13:3] : n_theta[13:3];
        n_seg   = n_pos[10:8];
        n_frac  = n_pos[7:1];
        n_sine.mag = xysp_pkg::SINE_BASE[n_seg]
                   + xysp_pkg::MAG_W'(xysp_pkg::SINE_SLOPE[n_seg])
                   * xysp_pkg::MAG_W'(n_frac);
        n_sine.neg = n_theta[15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= n_sine;
        end
    end

    assign o_valid = r_valid;
    assign o_sine  = r_sine;

endmodule

`default_nettype wire

@@ design/xysp_color.sv @@
// Wave sum and HSV output register.
`default_nettype none

module xysp_color (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire xysp_pkg::t_axis_sine i_sine_x,
    input  wire xysp_pkg::t_axis_sine i_sine_y,
    input  wire xysp_pkg::t_cfg       i_cfg,
    output logic                      o_valid,
    output xysp_pkg::t_out_beat       o_data
);

    logic                   r_valid;
    xysp_pkg::t_out_beat    r_data;

    logic [15:0]            n_half_x, n_half_y;
    logic [15:0]            n_sum;
    xysp_pkg::t_out_beat    n_data;

    always_comb begin
        // Halving the magnitude before the sign gives truncation toward zero.
        n_half_x = 16'(i_sine_x.mag[xysp_pkg::MAG_W-1:1]);
        n_half_y = 16'(i_sine_y.mag[xysp_pkg::MAG_W-1:1]);
        if (i_sine_x.neg) begin
            n_half_x = 16'd0 - n_half_x;
        end
        if (i_sine_y.neg) begin
            n_half_y = 16'd0 - n_half_y;
        end
        n_sum        = n_half_x + n_half_y;
        n_data.hue16 = n_sum + {i_cfg.base_hue, 8'h00};
        n_data.sat16 = {i_cfg.base_sat, 8'h00};
        n_data.val16 = i_cfg.wave_drives_value ? n_sum + xysp_pkg::VAL_OFFSET
                                               : {i_cfg.base_val, 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ design/xy_sine_wave_pixel_color.sv @@
// Top level of the two-axis sine plasma color generator.
//
// Input channel: i_in_valid / o_in_stall carry one beat of t_in_beat. A beat
// with mode clear is a frame tick; it advances the X and Y phase offsets by
// the step registers on the edge it is taken and yields no output beat. A
// beat with mode set is a pixel and yields exactly one t_out_beat color.
// Output channel: o_out_valid / i_out_stall. A pixel taken on an edge passes
// through the lookup, scale, reciprocal divide, sine and output stages, each
// holding one register; its color shows at o_out_data from the output register.
// Unstalled, throughput is one beat per clock and every stage takes a beat each cycle.
// The whole pipeline advances together, so i_out_stall on a waiting output
// beat freezes all stages and raises o_in_stall in the same cycle; bubbles
// are not squeezed out. Configuration writes (i_cfg_valid, always ready)
// must only be made while the pipeline is empty.
// Synchronous reset (i_rst_n low) empties the pipeline, clears both phase
// offsets and loads the register defaults.
`default_nettype none

module xy_sine_wave_pixel_color (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire xysp_pkg::t_in_beat     i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output xysp_pkg::t_out_beat         o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire xysp_pkg::t_reg_idx     i_cfg_index,
    input  wire logic [7:0]             i_cfg_data
);

    // Configuration registers and the frame phase state.
    xysp_pkg::t_cfg r_cfg;
    logic [7:0]     r_step_x, r_step_y;
    logic [15:0]    r_phase_x, r_phase_y;

    logic                   en;
    logic                   tick_acc;
    logic                   pix_valid;
    logic                   ang_valid;
    xysp_pkg::t_axis_ang    ang_x, ang_y;
    logic                   sine_valid_x, sine_valid_y;
    xysp_pkg::t_axis_sine   sine_x, sine_y;

    // The pipeline moves whenever the output register is free or being taken.
    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign tick_acc    = i_in_valid && en && (i_in_data.mode == xysp_pkg::MODE_TICK);
    assign pix_valid   = i_in_valid && (i_in_data.mode == xysp_pkg::MODE_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_x            <= 8'd127;
            r_cfg.freq_y            <= 8'd127;
            r_cfg.base_hue          <= 8'd0;
            r_cfg.base_sat          <= 8'd255;
            r_cfg.base_val          <= 8'd255;
            r_cfg.wave_drives_value <= 1'b1;
            r_step_x                <= 8'd0;
            r_step_y                <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                xysp_pkg::REG_FREQ_X:   r_cfg.freq_x            <= i_cfg_data;
                xysp_pkg::REG_FREQ_Y:   r_cfg.freq_y            <= i_cfg_data;
                xysp_pkg::REG_STEP_X:   r_step_x                <= i_cfg_data;
                xysp_pkg::REG_STEP_Y:   r_step_y                <= i_cfg_data;
                xysp_pkg::REG_BASE_HUE: r_cfg.base_hue          <= i_cfg_data;
                xysp_pkg::REG_BASE_SAT: r_cfg.base_sat          <= i_cfg_data;
                xysp_pkg::REG_BASE_VAL: r_cfg.base_val          <= i_cfg_data;
                xysp_pkg::REG_WAVE_VAL: r_cfg.wave_drives_value <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A pixel samples the phases as they stand when it enters, so every
    // tick taken ahead of it has already been applied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_x <= 16'd0;
            r_phase_y <= 16'd0;
        end else if (tick_acc) begin
            r_phase_x <= r_phase_x + 16'(r_step_x);
            r_phase_y <= r_phase_y + 16'(r_step_y);
        end
    end

    xysp_angle u_angle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (pix_valid),
        .i_pixel_x (i_in_data.pixel_x),
        .i_pixel_y (i_in_data.pixel_y),
        .i_phase_x (r_phase_x),
        .i_phase_y (r_phase_y),
        .i_cfg     (r_cfg),
        .o_valid   (ang_valid),
        .o_ang_x   (ang_x),
        .o_ang_y   (ang_y)
    );

    xysp_sine u_sine_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ang_valid),
        .i_ang   (ang_x),
        .o_valid (sine_valid_x),
        .o_sine  (sine_x)
    );

    xysp_sine u_sine_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ang_valid),
        .i_ang   (ang_y),
        .o_valid (sine_valid_y),
        .o_sine  (sine_y)
    );

    xysp_color u_color (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (sine_valid_x),
        .i_sine_x (sine_x),
        .i_sine_y (sine_y),
        .i_cfg    (r_cfg),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data)
    );

`ifndef SYNTH
    // Both axis lanes must carry the same beat in lockstep.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sine_valid_x == sine_valid_y)
        else $error("axis sine lanes out of step");

    // A beat in the sine stage reaches the output register when not stalled.
    a_sine_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sine_valid_x && en) |=> o_out_valid)
        else $error("pixel beat lost between sine and output stage");

    // While the input is stalled no tick can slip in and move the phases.
    a_phase_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> ($stable(r_phase_x) && $stable(r_phase_y)))
        else $error("phase changed while input stalled");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

@@ sim/xysp_color_checker.sv @@
// Checker that watches the color block's channels, predicts each color and compares.
module xysp_color_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire xysp_pkg::t_in_beat  i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire xysp_pkg::t_out_beat i_out_data,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire xysp_pkg::t_reg_idx  i_cfg_index,
    input  wire logic [7:0]          i_cfg_data,
    input  wire logic                i_done,
    output int                       o_fails,
    output int                       o_pending,
    output int                       o_colors,
    output int                       o_ticks,
    output int                       o_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned X_SPAN = 8 * 8 * 256;
    localparam int unsigned Y_SPAN = 11 * 256;
    localparam int unsigned X_MULT = 2;
    localparam int unsigned Y_MULT = 1;

    localparam logic [14:0] SEG_BASE [8] = '{
        15'd0, 15'd6393, 15'd12539, 15'd18204,
        15'd23170, 15'd27245, 15'd30273, 15'd32137
    };
    localparam logic [5:0] SEG_SLOPE [8] = '{
        6'd49, 6'd48, 6'd44, 6'd38, 6'd31, 6'd23, 6'd14, 6'd4
    };

    logic [7:0]           cfg_regs [8];
    logic [15:0]          wave_phase_x;
    logic [15:0]          wave_phase_y;
    xysp_pkg::t_out_beat  colors_due [$];
    bit                   done_seen;

    // Eight linear segments per quarter wave; the upper angle bits fold and negate.
    function automatic int sine_lookup(input logic [15:0] theta);
        logic [10:0] pos;
        logic [2:0]  seg;
        int          mag;
        pos = theta[13:3];
        if (theta[14]) begin
            pos = 11'd2047 - pos;
        end
        seg = pos[10:8];
        mag = int'(SEG_BASE[seg]) + int'(SEG_SLOPE[seg]) * int'(pos[7:1]);
        return theta[15] ? -mag : mag;
    endfunction

    // All scaling is 32-bit unsigned; only the low 16 bits form the angle.
    function automatic int axis_half_wave(input logic [7:0] coord, input int unsigned span,
                                          input logic [7:0] freq, input int unsigned mult,
                                          input logic [15:0] phase);
        logic [31:0] ang;
        ang = (32'(coord) << 8) * 32'd65535;
        ang = ang / span;
        ang = ang * 32'(freq);
        ang = ang * mult;
        ang = ang / 32'd255;
        ang = ang + 32'(phase);
        return sine_lookup(ang[15:0]) / 2;
    endfunction

    function automatic xysp_pkg::t_out_beat plasma_color(input logic [7:0] px,
                                                          input logic [7:0] py);
        xysp_pkg::t_out_beat c;
        logic [31:0]         sum;
        sum = axis_half_wave(px, X_SPAN, cfg_regs[xysp_pkg::REG_FREQ_X], X_MULT,
                             wave_phase_x)
            + axis_half_wave(py, Y_SPAN, cfg_regs[xysp_pkg::REG_FREQ_Y], Y_MULT,
                             wave_phase_y);
        c.hue16 = sum[15:0] + {cfg_regs[xysp_pkg::REG_BASE_HUE], 8'd0};
        c.sat16 = {cfg_regs[xysp_pkg::REG_BASE_SAT], 8'd0};
        c.val16 = cfg_regs[xysp_pkg::REG_WAVE_VAL][0]
                ? sum[15:0] + 16'd32767
                : {cfg_regs[xysp_pkg::REG_BASE_VAL], 8'd0};
        return c;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            o_fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        xysp_pkg::t_out_beat want;
        if (!i_rst_n) begin
            cfg_regs[xysp_pkg::REG_FREQ_X]   = 8'd127;
            cfg_regs[xysp_pkg::REG_FREQ_Y]   = 8'd127;
            cfg_regs[xysp_pkg::REG_STEP_X]   = 8'd0;
            cfg_regs[xysp_pkg::REG_STEP_Y]   = 8'd0;
            cfg_regs[xysp_pkg::REG_BASE_HUE] = 8'd0;
            cfg_regs[xysp_pkg::REG_BASE_SAT] = 8'd255;
            cfg_regs[xysp_pkg::REG_BASE_VAL] = 8'd255;
            cfg_regs[xysp_pkg::REG_WAVE_VAL] = 8'd1;
            wave_phase_x = '0;
            wave_phase_y = '0;
            colors_due.delete();
            done_seen = 1'b0;
            o_fails   = 0;
            o_colors  = 0;
            o_ticks   = 0;
            o_writes  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cfg_regs[i_cfg_index] = i_cfg_data;
                o_writes++;
            end
            // Results leave before new pixels are queued, so an early color cannot
            // match against a pixel taken on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (colors_due.size() == 0) begin
                    $error("color beat arrived with no pixel pending: %h", i_out_data);
                    o_fails++;
                end else begin
                    want = colors_due.pop_front();
                    check_field("hue16", want.hue16, i_out_data.hue16);
                    check_field("sat16", want.sat16, i_out_data.sat16);
                    check_field("val16", want.val16, i_out_data.val16);
                    o_colors++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.mode == xysp_pkg::MODE_TICK) begin
                    wave_phase_x = wave_phase_x + 16'(cfg_regs[xysp_pkg::REG_STEP_X]);
                    wave_phase_y = wave_phase_y + 16'(cfg_regs[xysp_pkg::REG_STEP_Y]);
                    o_ticks++;
                end else begin
                    colors_due.push_back(plasma_color(i_in_data.pixel_x, i_in_data.pixel_y));
                end
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (colors_due.size() != 0) begin
                    $error("%0d pixel colors never arrived", colors_due.size());
                    o_fails += colors_due.size();
                end
            end
        end
        o_pending = colors_due.size();
    end

endmodule

@@ sim/xy_sine_wave_pixel_color_tb.sv @@
// Stimulus and verdict for the two-axis sine color block, with the checker beside it.
module xy_sine_wave_pixel_color_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Percentage of cycles in which either side idles when it is allowed to.
    localparam int IDLE_PCT     = 21;
    // Idle margin after the last color; frame ticks never sit in the pipeline.
    localparam int PIPE_FLUSH   = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS  = 160;
    localparam int RAND_PHASES  = 8;
    localparam int LIMIT_CYCLES = 400000;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    xysp_pkg::t_in_beat   i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    xysp_pkg::t_out_beat  o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    xysp_pkg::t_reg_idx   i_cfg_index = xysp_pkg::REG_FREQ_X;
    logic [7:0]           i_cfg_data  = '0;
    logic                 run_done    = 1'b0;

    int fails;
    int pending;
    int colors;
    int ticks;
    int writes;

    // Control between the sender and the receiver. in_calm and out_calm switch
    // random idling off; each bump of hold_reqs asks for one long output hold-off.
    bit in_calm   = 1'b0;
    bit out_calm  = 1'b0;
    int hold_reqs = 0;
    int settings_used = 0;
    int cycle_cnt = 0;

    xy_sine_wave_pixel_color dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    xysp_color_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_done      (run_done),
        .o_fails     (fails),
        .o_pending   (pending),
        .o_colors    (colors),
        .o_ticks     (ticks),
        .o_writes    (writes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A hung handshake ends the run here instead of spinning forever.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side. All drives happen on the rising edge; a requested hold-off
    // keeps the stall high, which backs the whole pipeline up into the input
    // channel while the sender keeps offering beats.
    initial begin : result_side
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != served) begin
                served++;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= !out_calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Offers one input beat and returns on the edge that takes it. The stall is
    // sampled at the falling edge, where it is settled and no update races it.
    // Valid is left high so a following beat can go out back to back.
    task automatic push_beat(input logic kind, input logic [7:0] px, input logic [7:0] py);
        logic stalled;
        if (!in_calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{mode: kind, pixel_x: px, pixel_y: py};
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    // Stops offering beats until every predicted color is back, which leaves no
    // pixel in the pipeline, so that a register write is safe; then idles through the PIPE_FLUSH margin.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    task automatic write_reg(input xysp_pkg::t_reg_idx idx, input logic [7:0] value);
        logic ready;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Favors the ends of the range a quarter of the time.
    function automatic logic [7:0] pick_setting();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) begin
            return 8'd0;
        end else if (roll == 1) begin
            return 8'd255;
        end
        return 8'($urandom);
    endfunction

    // Each coordinate lands inside the display area half of the time, where the angle
    // scale stays below a full turn; otherwise it uses the whole coordinate range.
    task automatic random_beats(input int count, input int tick_pct);
        logic [7:0] px;
        logic [7:0] py;
        repeat (count) begin
            px = $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom);
            py = $urandom_range(1) ? 8'($urandom_range(10)) : 8'($urandom);
            if ($urandom_range(99) < tick_pct) begin
                push_beat(xysp_pkg::MODE_TICK, px, py);
            end else begin
                push_beat(xysp_pkg::MODE_PIXEL, px, py);
            end
        end
    endtask

    initial begin : stimulus
        int tick_pct;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners of the coordinate space, the display edges,
        // and a tick with nonzero pixel fields that must leave the phases alone
        // while both steps are zero.
        settings_used++;
        push_beat(xysp_pkg::MODE_PIXEL, 8'd0, 8'd0);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd255, 8'd255);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd63, 8'd10);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd64, 8'd11);
        push_beat(xysp_pkg::MODE_TICK, 8'd255, 8'd255);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd255, 8'd0);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd0, 8'd255);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd128, 8'd128);

        // Frequencies, steps and base hue at their top value, base saturation and value
        // at zero, and the value-source bit written with its upper bits set and bit zero clear.
        drain_results();
        settings_used++;
        write_reg(xysp_pkg::REG_FREQ_X, 8'd255);
        write_reg(xysp_pkg::REG_FREQ_Y, 8'd255);
        write_reg(xysp_pkg::REG_STEP_X, 8'd255);
        write_reg(xysp_pkg::REG_STEP_Y, 8'd255);
        write_reg(xysp_pkg::REG_BASE_HUE, 8'd255);
        write_reg(xysp_pkg::REG_BASE_SAT, 8'd0);
        write_reg(xysp_pkg::REG_BASE_VAL, 8'd0);
        write_reg(xysp_pkg::REG_WAVE_VAL, 8'hFE);
        push_beat(xysp_pkg::MODE_TICK, 8'd0, 8'd0);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd255, 8'd255);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd0, 8'd0);
        push_beat(xysp_pkg::MODE_TICK, 8'd170, 8'd85);
        push_beat(xysp_pkg::MODE_TICK, 8'd85, 8'd170);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd32, 8'd5);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd255, 8'd255);

        // Zero frequencies leave only the phase offsets in the angle.
        drain_results();
        settings_used++;
        write_reg(xysp_pkg::REG_FREQ_X, 8'd0);
        write_reg(xysp_pkg::REG_FREQ_Y, 8'd0);
        write_reg(xysp_pkg::REG_STEP_X, 8'd1);
        write_reg(xysp_pkg::REG_STEP_Y, 8'd128);
        write_reg(xysp_pkg::REG_BASE_HUE, 8'd128);
        write_reg(xysp_pkg::REG_BASE_SAT, 8'd255);
        write_reg(xysp_pkg::REG_BASE_VAL, 8'd128);
        write_reg(xysp_pkg::REG_WAVE_VAL, 8'h01);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd255, 8'd255);
        push_beat(xysp_pkg::MODE_TICK, 8'd0, 8'd0);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd100, 8'd200);
        push_beat(xysp_pkg::MODE_TICK, 8'd0, 8'd0);
        push_beat(xysp_pkg::MODE_PIXEL, 8'd0, 8'd0);

        // Random phases, each under fresh register settings. The second phase
        // runs with no idling on either side; the fourth carries the long
        // output hold-off after its first 30 beats.
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            settings_used++;
            in_calm  = (p == 1);
            out_calm <= (p == 1);
            write_reg(xysp_pkg::REG_FREQ_X, pick_setting());
            write_reg(xysp_pkg::REG_FREQ_Y, pick_setting());
            write_reg(xysp_pkg::REG_STEP_X, pick_setting());
            write_reg(xysp_pkg::REG_STEP_Y, pick_setting());
            write_reg(xysp_pkg::REG_BASE_HUE, pick_setting());
            write_reg(xysp_pkg::REG_BASE_SAT, pick_setting());
            write_reg(xysp_pkg::REG_BASE_VAL, pick_setting());
            write_reg(xysp_pkg::REG_WAVE_VAL, 8'($urandom));
            tick_pct = $urandom_range(10, 40);
            if (p == 3) begin
                random_beats(30, tick_pct);
                hold_reqs <= hold_reqs + 1;
                random_beats(PHASE_BEATS - 30, tick_pct);
            end else begin
                random_beats(PHASE_BEATS, tick_pct);
            end
        end

        drain_results();
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Run covered %0d pixel colors and %0d frame ticks", colors, ticks);
        $display("under %0d register settings, %0d register writes in all",
                 settings_used, writes);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/xysp_pkg.sv
design/xysp_angle.sv
design/xysp_sine.sv
design/xysp_color.sv
design/xy_sine_wave_pixel_color.sv
sim/xysp_color_checker.sv
sim/xy_sine_wave_pixel_color_tb.sv
